// ===== rtl/core/i2cm2b_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm2b_pkg
// Shared types and codes for the two-byte-address I2C register sequencer.
// ----------------------------------------------------------------------------
package i2cm2b_pkg;

    // action codes carried on s_tuser
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_EVENT = 2'd2;

    // bus status codes
    localparam logic [2:0] ST_START_DONE = 3'd0;
    localparam logic [2:0] ST_ACK        = 3'd1;
    localparam logic [2:0] ST_NACK       = 3'd2;
    localparam logic [2:0] ST_STOP_DONE  = 3'd3;

    // control word bits
    localparam logic [3:0] CTL_TRIG = 4'b0001;
    localparam logic [3:0] CTL_STA  = 4'b0010;
    localparam logic [3:0] CTL_STO  = 4'b0100;
    localparam logic [3:0] CTL_AA   = 4'b1000;

    localparam int IN_WIDTH  = 56;
    localparam int OUT_WIDTH = 40;

    // result word, lowest bit is send_valid
    typedef struct packed {
        logic [15:0] bytes_moved;
        logic        done_res;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        payload_taken;
        logic        ctl_ack;
        logic        ctl_stop;
        logic        ctl_start;
        logic        ctl_trigger;
        logic [7:0]  send_byte;
        logic        send_valid;
    } res_t;

endpackage

// ===== rtl/core/i2c_master_two_byte_register_transfer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_two_byte_register_transfer
// Master-side sequencer for I2C register transfers with a 16-bit register
// address: turns begin items and bus status events into transmit bytes and
// control words.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser: action; s_tdata: item fields
// m_*       out  m_tvalid/m_tready  m_tdata: result fields
// cfg_*     in   cfg_wen            cfg_wdata: slave address
//
// One word per cycle while s_tready is high; results are registered.
// An output register plus a skid register decouple the two sides, so input
// is taken while a result waits; s_tready drops only when both are full.
// Events while idle and unused action codes give no result word.
// Reset is asynchronous, active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module i2c_master_two_byte_register_transfer
    import i2cm2b_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [6:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] action
    input  logic [1:0]           s_tuser,
    // [15:0] reg_address, [31:16] request_length, [34:32] bus_status,
    // [42:35] payload_byte, [50:43] bus_byte, rest zero
    input  logic [IN_WIDTH-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] send_valid, [8:1] send_byte, [9] ctl_trigger, [10] ctl_start,
    // [11] ctl_stop, [12] ctl_ack, [13] payload_taken, [14] rx_valid,
    // [22:15] rx_byte, [23] done_res, [39:24] bytes_moved
    output logic [OUT_WIDTH-1:0] m_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_ADDR   = 3'd2,
        PH_DATA   = 3'd3,
        PH_RSTART = 3'd4,
        PH_RDADDR = 3'd5,
        PH_RDATA  = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        is_read_reg, is_read_next;
    logic        low_pend_reg, low_pend_next;
    logic [15:0] tgt_reg_reg, tgt_reg_next;
    logic [15:0] tgt_len_reg, tgt_len_next;
    logic [15:0] count_reg, count_next;
    logic [3:0]  ctl_reg, ctl_next;
    logic [6:0]  slave_address_reg;

    logic        out_valid_reg, skid_valid_reg;
    res_t        out_reg, skid_reg;
    res_t        res;
    logic        has_res;

    logic [15:0] in_reg_address;
    logic [15:0] in_length;
    logic [2:0]  in_status;
    logic [7:0]  in_payload;
    logic [7:0]  in_bus_byte;
    logic [15:0] count_inc;
    logic [15:0] len_m1;
    logic        accept, pop, push;

    assign in_reg_address = s_tdata[15:0];
    assign in_length      = s_tdata[31:16];
    assign in_status      = s_tdata[34:32];
    assign in_payload     = s_tdata[42:35];
    assign in_bus_byte    = s_tdata[50:43];

    assign count_inc = count_reg + 16'd1;
    assign len_m1    = tgt_len_reg - 16'd1;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign push     = accept && has_res;

    always_comb
    begin
        phase_next    = phase_reg;
        is_read_next  = is_read_reg;
        low_pend_next = low_pend_reg;
        tgt_reg_next  = tgt_reg_reg;
        tgt_len_next  = tgt_len_reg;
        count_next    = count_reg;
        ctl_next      = ctl_reg;
        res           = '0;
        has_res       = 1'b0;

        if (s_tuser == ACT_WRITE || s_tuser == ACT_READ)
        begin
            has_res       = 1'b1;
            is_read_next  = (s_tuser == ACT_READ);
            tgt_reg_next  = in_reg_address;
            tgt_len_next  = in_length;
            count_next    = '0;
            low_pend_next = 1'b1;
            ctl_next      = '0;
            phase_next    = PH_START;
            res.ctl_start = 1'b1;
        end
        else if (s_tuser == ACT_EVENT && phase_reg != PH_IDLE)
        begin
            has_res = 1'b1;
            priority case (in_status)
                ST_START_DONE:
                begin
                    if (!is_read_reg || phase_reg == PH_START)
                    begin
                        res.send_valid = 1'b1;
                        res.send_byte  = {slave_address_reg, 1'b0};
                        phase_next     = PH_ADDR;
                    end
                    else if (phase_reg == PH_RSTART)
                    begin
                        res.send_valid = 1'b1;
                        res.send_byte  = {slave_address_reg, 1'b1};
                        phase_next     = PH_RDADDR;
                    end
                    ctl_next = CTL_TRIG;
                end
                ST_ACK:
                begin
                    if (phase_reg == PH_ADDR)
                    begin
                        res.send_valid = 1'b1;
                        res.send_byte  = tgt_reg_reg[15:8];
                        phase_next     = PH_DATA;
                    end
                    else if (phase_reg == PH_DATA)
                    begin
                        if (low_pend_reg)
                        begin
                            res.send_valid = 1'b1;
                            res.send_byte  = tgt_reg_reg[7:0];
                            low_pend_next  = 1'b0;
                        end
                        else if (is_read_reg)
                        begin
                            ctl_next   = CTL_TRIG | CTL_STA;
                            phase_next = PH_RSTART;
                        end
                        else if (count_reg < tgt_len_reg)
                        begin
                            res.send_valid    = 1'b1;
                            res.send_byte     = in_payload;
                            res.payload_taken = 1'b1;
                            count_next        = count_inc;
                        end
                        else
                        begin
                            ctl_next = CTL_TRIG | CTL_STO;
                        end
                    end
                    else if (is_read_reg)
                    begin
                        if (phase_reg == PH_RDADDR)
                        begin
                            ctl_next   = CTL_TRIG | CTL_AA;
                            phase_next = PH_RDATA;
                        end
                        else
                        begin
                            res.rx_valid = 1'b1;
                            res.rx_byte  = in_bus_byte;
                            count_next   = count_inc;
                            // ACK all but the final byte
                            ctl_next     = (count_inc < len_m1) ? (CTL_TRIG | CTL_AA)
                                                                : CTL_TRIG;
                        end
                    end
                end
                ST_NACK:
                begin
                    if (is_read_reg && phase_reg == PH_RDATA)
                    begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = in_bus_byte;
                        count_next   = count_inc;
                    end
                    ctl_next = CTL_TRIG | CTL_STO;
                end
                ST_STOP_DONE:
                begin
                    ctl_next     = CTL_TRIG;
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                end
                default:
                begin
                    ctl_next = CTL_TRIG | CTL_STO;
                end
            endcase
            res.ctl_trigger = ctl_next[0];
            res.ctl_start   = ctl_next[1];
            res.ctl_stop    = ctl_next[2];
            res.ctl_ack     = ctl_next[3];
            res.bytes_moved = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= '0;
            phase_reg         <= PH_IDLE;
            is_read_reg       <= 1'b0;
            low_pend_reg      <= 1'b1;
            tgt_reg_reg       <= '0;
            tgt_len_reg       <= '0;
            count_reg         <= '0;
            ctl_reg           <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                slave_address_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg    <= phase_next;
                is_read_reg  <= is_read_next;
                low_pend_reg <= low_pend_next;
                tgt_reg_reg  <= tgt_reg_next;
                tgt_len_reg  <= tgt_len_next;
                count_reg    <= count_next;
                ctl_reg      <= ctl_next;
            end
            if (!out_valid_reg || pop)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result data path, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/core/i2cm2b_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm2b_checker
// Port-level checks on the result words of the register sequencer.
// ----------------------------------------------------------------------------
module i2cm2b_checker
    import i2cm2b_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_WIDTH-1:0] m_tdata
);

    res_t r;
    assign r = m_tdata;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // a word never both sends and receives a byte
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(r.send_valid && r.rx_valid))
        else $error("send and receive in one word");

    // consumed payload must go out as the transmit byte
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.payload_taken |-> r.send_valid && !r.rx_valid)
        else $error("payload taken without transmit");

    // transfer end carries a plain trigger, nothing sent
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.done_res |-> r.ctl_trigger && !r.ctl_start && !r.ctl_stop
                                   && !r.send_valid && !r.rx_valid)
        else $error("bad word at transfer end");

    // unused byte lanes read zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r.send_valid || r.send_byte == 8'd0)
                     && (r.rx_valid || r.rx_byte == 8'd0))
        else $error("stale byte in idle lane");

endmodule

bind i2c_master_two_byte_register_transfer i2cm2b_checker u_i2cm2b_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/i2c_register_transfer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_transfer_checker
// Watches both streams of the register transfer sequencer, tracks the
// sequencer state itself, and checks every result word, field by field,
// against the control word and bytes that each accepted word should give.
// ----------------------------------------------------------------------------
module i2c_register_transfer_checker
    import i2cm2b_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [6:0]           cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [1:0]           s_tuser,
    input  logic [IN_WIDTH-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_WIDTH-1:0] m_tdata,
    output int                   mismatches,
    output int                   results_due
);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_ADDR,
        SEQ_DATA,
        SEQ_RSTART,
        SEQ_RDADDR,
        SEQ_RDATA
    } seq_phase_t;

    seq_phase_t  seq_phase;
    logic        read_mode;
    logic        low_addr_due;
    logic [15:0] target_reg;
    logic [15:0] xfer_len;
    logic [15:0] xfer_count;
    logic [3:0]  held_ctl;
    logic [6:0]  dev_addr;

    res_t        expected_words[$];

    initial
    begin
        mismatches  = 0;
        results_due = 0;
    end

    task automatic clear_sequencer();
        seq_phase    = SEQ_IDLE;
        read_mode    = 1'b0;
        low_addr_due = 1'b1;
        target_reg   = '0;
        xfer_len     = '0;
        xfer_count   = '0;
        held_ctl     = '0;
        dev_addr     = '0;
        expected_words.delete();
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // works out the result word (if any) for one accepted input word
    task automatic predict_word(input logic [1:0] act, input logic [IN_WIDTH-1:0] d);
        logic [15:0] reg_in;
        logic [15:0] len_in;
        logic [2:0]  status;
        logic [7:0]  payload;
        logic [7:0]  rx;
        logic [15:0] len_m1;
        res_t        r;
        reg_in  = d[15:0];
        len_in  = d[31:16];
        status  = d[34:32];
        payload = d[42:35];
        rx      = d[50:43];
        r       = '0;

        if (act == ACT_WRITE || act == ACT_READ)
        begin
            read_mode    = (act == ACT_READ);
            target_reg   = reg_in;
            xfer_len     = len_in;
            xfer_count   = '0;
            low_addr_due = 1'b1;
            held_ctl     = '0;
            seq_phase    = SEQ_START;
            r.ctl_start  = 1'b1;
            expected_words.push_back(r);
            return;
        end
        if (act != ACT_EVENT || seq_phase == SEQ_IDLE)
            return;

        case (status)
            ST_START_DONE:
            begin
                if (!read_mode || seq_phase == SEQ_START)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = {dev_addr, 1'b0};
                    seq_phase    = SEQ_ADDR;
                end
                else if (seq_phase == SEQ_RSTART)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = {dev_addr, 1'b1};
                    seq_phase    = SEQ_RDADDR;
                end
                held_ctl = CTL_TRIG;
            end
            ST_ACK:
            begin
                if (seq_phase == SEQ_ADDR)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = target_reg[15:8];
                    seq_phase    = SEQ_DATA;
                end
                else if (seq_phase == SEQ_DATA)
                begin
                    if (low_addr_due)
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte  = target_reg[7:0];
                        low_addr_due = 1'b0;
                    end
                    else if (read_mode)
                    begin
                        held_ctl  = CTL_TRIG | CTL_STA;
                        seq_phase = SEQ_RSTART;
                    end
                    else if (xfer_count < xfer_len)
                    begin
                        r.send_valid    = 1'b1;
                        r.send_byte     = payload;
                        r.payload_taken = 1'b1;
                        xfer_count      = xfer_count + 16'd1;
                    end
                    else
                        held_ctl = CTL_TRIG | CTL_STO;
                end
                else if (read_mode)
                begin
                    if (seq_phase == SEQ_RDADDR)
                    begin
                        held_ctl  = CTL_TRIG | CTL_AA;
                        seq_phase = SEQ_RDATA;
                    end
                    else
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = rx;
                        xfer_count = xfer_count + 16'd1;
                        // a zero length wraps here, so every byte gets ACKed
                        len_m1     = xfer_len - 16'd1;
                        held_ctl   = (xfer_count < len_m1) ? (CTL_TRIG | CTL_AA) : CTL_TRIG;
                    end
                end
            end
            ST_NACK:
            begin
                if (read_mode && seq_phase == SEQ_RDATA)
                begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = rx;
                    xfer_count = xfer_count + 16'd1;
                end
                held_ctl = CTL_TRIG | CTL_STO;
            end
            ST_STOP_DONE:
            begin
                held_ctl   = CTL_TRIG;
                r.done_res = 1'b1;
                seq_phase  = SEQ_IDLE;
            end
            default:
                held_ctl = CTL_TRIG | CTL_STO;
        endcase

        r.ctl_trigger = held_ctl[0];
        r.ctl_start   = held_ctl[1];
        r.ctl_stop    = held_ctl[2];
        r.ctl_ack     = held_ctl[3];
        r.bytes_moved = xfer_count;
        expected_words.push_back(r);
    endtask

    task automatic compare_word(input res_t got, input res_t want);
        check_field("send_valid", 16'(got.send_valid), 16'(want.send_valid));
        check_field("send_byte", 16'(got.send_byte), 16'(want.send_byte));
        check_field("ctl_trigger", 16'(got.ctl_trigger), 16'(want.ctl_trigger));
        check_field("ctl_start", 16'(got.ctl_start), 16'(want.ctl_start));
        check_field("ctl_stop", 16'(got.ctl_stop), 16'(want.ctl_stop));
        check_field("ctl_ack", 16'(got.ctl_ack), 16'(want.ctl_ack));
        check_field("payload_taken", 16'(got.payload_taken), 16'(want.payload_taken));
        check_field("rx_valid", 16'(got.rx_valid), 16'(want.rx_valid));
        check_field("rx_byte", 16'(got.rx_byte), 16'(want.rx_byte));
        check_field("done_res", 16'(got.done_res), 16'(want.done_res));
        check_field("bytes_moved", got.bytes_moved, want.bytes_moved);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            clear_sequencer();
        else
        begin
            if (cfg_wen)
                dev_addr = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("result word %h with nothing expected",
                                              m_tdata));
                else
                    compare_word(res_t'(m_tdata), expected_words.pop_front());
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata);
        end
        results_due = expected_words.size();
    end

endmodule

// ===== bench/tb_i2c_master_two_byte_register_transfer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_two_byte_register_transfer
// Drives begin words and bus status events into the sequencer: a directed
// pass over the corner cases, then mostly well-formed write and read
// transfers with corrupted, abandoned and stray events, under four mixes
// of sender gaps and receiver stalls. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_i2c_master_two_byte_register_transfer;
    import i2cm2b_pkg::*;

    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int WORDS_PER_PHASE = 275;
    localparam int DATA_CAP        = 12;

    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [2:0] ST_ARB_LOST  = 3'd4;
    localparam logic [2:0] ST_OTHER     = 3'd5;
    localparam logic [2:0] ST_RSVD6     = 3'd6;
    localparam logic [2:0] ST_RSVD7     = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [6:0]           cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [1:0]           s_tuser   = '0;
    logic [IN_WIDTH-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_WIDTH-1:0] m_tdata;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int words_sent   = 0;
    int cycle_count  = 0;
    int mismatches;
    int results_due;

    always #2 clk = ~clk;

    i2c_master_two_byte_register_transfer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2c_register_transfer_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_i2c_master_two_byte_register_transfer: FAIL");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so the next word follows without a bubble
    task automatic put_word(input logic [1:0] act, input logic [15:0] reg_addr,
                            input logic [15:0] len, input logic [2:0] status,
                            input logic [7:0] payload, input logic [7:0] rx,
                            input bit counted);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, rx, payload, status, len, reg_addr};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (counted)
            words_sent++;
    endtask

    task automatic begin_word(input logic [1:0] act, input logic [15:0] reg_addr,
                              input logic [15:0] len);
        put_word(act, reg_addr, len, 3'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    endtask

    task automatic event_word(input logic [2:0] status, input logic [7:0] payload,
                              input logic [7:0] rx);
        put_word(ACT_EVENT, 16'($urandom), 16'($urandom), status, payload, rx, 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        // events that give no word may still be in flight
        repeat (4) @(negedge clk);
    endtask

    task automatic set_slave(input logic [6:0] addr);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= addr;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic run_transfer();
        logic [1:0]  act;
        logic [15:0] len;
        logic [2:0]  plan[$];
        int          n_data;
        int          roll;
        act = $urandom_range(1) ? ACT_READ : ACT_WRITE;
        len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(DATA_CAP));
        begin_word(act, 16'($urandom), len);
        plan = {ST_START_DONE, ST_ACK, ST_ACK, ST_ACK};
        if (act == ACT_WRITE)
        begin
            n_data = (len > DATA_CAP) ? $urandom_range(DATA_CAP) : int'(len);
            repeat (n_data) plan.push_back(ST_ACK);
            plan.push_back((len > DATA_CAP) ? ST_NACK : ST_ACK);
        end
        else
        begin
            plan.push_back(ST_ACK);
            plan.push_back(ST_START_DONE);
            plan.push_back(ST_ACK);
            if (len == 0 || len > DATA_CAP)
                n_data = $urandom_range(DATA_CAP);
            else
                n_data = int'(len) - 1;
            repeat (n_data) plan.push_back(ST_ACK);
            plan.push_back(ST_NACK);
        end
        plan.push_back(ST_STOP_DONE);

        foreach (plan[i])
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                return;     // abandoned mid-way, the next begin word takes over
            event_word((roll < 10) ? 3'($urandom) : plan[i], 8'($urandom), 8'($urandom));
            if (roll >= 10 && roll < 13)
                event_word(3'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // stray words: unused action code or events that may find the sequencer idle
    task automatic stray_words();
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(1))
                put_word(ACT_NONE, 16'($urandom), 16'($urandom), 3'($urandom),
                         8'($urandom), 8'($urandom), 1'b0);
            else
                put_word(ACT_EVENT, 16'($urandom), 16'($urandom), 3'($urandom),
                         8'($urandom), 8'($urandom), 1'b0);
        end
    endtask

    initial
    begin
        int target;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_slave(7'h7F);

        // directed corner cases
        put_word(ACT_EVENT, 16'h0000, 16'h0000, ST_ACK, 8'h00, 8'h00, 1'b0);
        put_word(ACT_NONE, 16'hFFFF, 16'hFFFF, ST_RSVD7, 8'hFF, 8'hFF, 1'b0);
        begin_word(ACT_WRITE, 16'hFFFF, 16'd1);
        event_word(ST_ACK, 8'h11, 8'h22);           // ack before the address: control held
        event_word(ST_START_DONE, 8'h00, 8'h00);
        event_word(ST_ACK, 8'h00, 8'h00);
        event_word(ST_ACK, 8'h00, 8'h00);
        event_word(ST_ACK, 8'hFF, 8'h00);
        event_word(ST_ACK, 8'h00, 8'h00);
        event_word(ST_STOP_DONE, 8'h00, 8'h00);
        begin_word(ACT_READ, 16'h0000, 16'd0);
        event_word(ST_START_DONE, 8'h00, 8'h00);
        repeat (4) event_word(ST_ACK, 8'h00, 8'h00);
        event_word(ST_START_DONE, 8'h00, 8'h00);
        event_word(ST_ACK, 8'h00, 8'h00);
        event_word(ST_ACK, 8'h00, 8'hFF);
        event_word(ST_START_DONE, 8'h00, 8'h00);   // read data phase: trigger only
        event_word(ST_NACK, 8'h00, 8'hA5);
        event_word(ST_STOP_DONE, 8'h00, 8'h00);
        begin_word(ACT_WRITE, 16'h8001, 16'hFFFF);
        event_word(ST_START_DONE, 8'h00, 8'h00);
        event_word(ST_ARB_LOST, 8'h00, 8'h00);
        event_word(ST_OTHER, 8'h00, 8'h00);
        event_word(ST_RSVD6, 8'h00, 8'h00);
        begin_word(ACT_READ, 16'h1234, 16'hFFFF);   // abandons the running write
        event_word(ST_NACK, 8'h00, 8'h00);
        event_word(ST_STOP_DONE, 8'h00, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_slave(7'h00);
                2: set_slave(7'h7F);
                default: set_slave(7'($urandom));
            endcase
            send_gap_pct = (ph == 1) ? 51 : (ph == 3) ? 19 : 0;
            stall_pct    = (ph == 2) ? 51 : (ph == 3) ? 19 : 0;
            target       = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
            begin
                run_transfer();
                if ($urandom_range(6) == 0)
                    stray_words();
                if ($urandom_range(40) == 0)
                    settle();
            end
        end

        s_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("tb_i2c_master_two_byte_register_transfer: PASS");
        else
            $display("tb_i2c_master_two_byte_register_transfer: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/i2cm2b_pkg.sv
rtl/core/i2c_master_two_byte_register_transfer.sv
rtl/core/i2cm2b_checker.sv
bench/i2c_register_transfer_checker.sv
bench/tb_i2c_master_two_byte_register_transfer.sv
